[design/tea_pkg.sv]
// Package with shared types, constants and round functions for the TEA block cipher.
package tea_pkg;

  // Number of full TEA rounds; each round takes two cells of the chain.
  localparam int unsigned ROUND_COUNT = 32;
  localparam int unsigned NUM_CELLS   = 2 * ROUND_COUNT;

  localparam logic [31:0] TEA_DELTA    = 32'h9E37_79B9;
  // Starting sum for decryption: delta times the round count, modulo 2^32.
  localparam logic [31:0] TEA_DEC_SUM  = 32'(64'(TEA_DELTA) * 64'(ROUND_COUNT));

  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_A      = 3'd0,
    CFG_KEY_B      = 3'd1,
    CFG_KEY_C      = 3'd2,
    CFG_KEY_D      = 3'd3,
    CFG_BYTE_ORDER = 3'd4
  } cfg_reg_e;

  // Request types.
  typedef enum logic {
    REQ_ENCRYPT = 1'b0,
    REQ_DECRYPT = 1'b1
  } req_type_e;

  // The 128-bit key as four words.
  typedef struct packed {
    logic [31:0] ka;
    logic [31:0] kb;
    logic [31:0] kc;
    logic [31:0] kd;
  } key_t;

  // Payload carried from one cell to the next.
  typedef struct packed {
    logic        dec;
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] sum;
  } stage_t;

  // TEA mixing function of one half.
  function automatic logic [31:0] tea_mix(input logic [31:0] v, input logic [31:0] sum,
                                          input logic [31:0] ka, input logic [31:0] kb);
    return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
  endfunction

  // Byte reversal of a 32-bit half, used for big-endian packing.
  function automatic logic [31:0] bswap32(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // Half of a block as a 32-bit word, in the selected byte order.
  function automatic logic [31:0] order_half(input logic [31:0] w, input logic big);
    return big ? bswap32(w) : w;
  endfunction

endpackage

[design/tea_if.sv]
// Channel interfaces of the TEA block cipher: request, response and configuration.
interface tea_req_if;
  import tea_pkg::*;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [63:0] block_in;

  modport source (output valid, output req_type, output block_in, input ready);
  modport sink   (input valid, input req_type, input block_in, output ready);
endinterface

interface tea_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_out;

  modport source (output valid, output block_out, input ready);
  modport sink   (input valid, input block_out, output ready);
endinterface

interface tea_cfg_if;
  import tea_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/tea_cfg.sv]
// Configuration register file: key words and byte-order setting.
module tea_cfg import tea_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  tea_cfg_if.sink       cfg,
  output key_t          key_o,
  output logic          byte_order_o
);

  key_t key_q;
  logic byte_order_q;

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Register write decode; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q        <= '0;
      byte_order_q <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_e'(cfg.index))
        CFG_KEY_A:      key_q.ka     <= cfg.data;
        CFG_KEY_B:      key_q.kb     <= cfg.data;
        CFG_KEY_C:      key_q.kc     <= cfg.data;
        CFG_KEY_D:      key_q.kd     <= cfg.data;
        CFG_BYTE_ORDER: byte_order_q <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign key_o        = key_q;
  assign byte_order_o = byte_order_q;

endmodule

[design/tea_cell.sv]
// One cell of the chain: a half round of TEA on the incoming word, held in its register.
module tea_cell import tea_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   phase_i,
  input  key_t   key_i,
  input  logic   valid_i,
  input  stage_t data_i,
  output logic   valid_o,
  output stage_t data_o
);

  logic        valid_q;
  stage_t      data_q, data_d;
  logic        upd_v1;
  logic [31:0] src, tgt, ka, kb, mix, res;

  // The first half of an encryption round updates v0, the second v1;
  // decryption runs the halves in the opposite order.
  assign upd_v1 = phase_i ^ data_i.dec;
  assign src    = upd_v1 ? data_i.v0 : data_i.v1;
  assign tgt    = upd_v1 ? data_i.v1 : data_i.v0;
  assign ka     = upd_v1 ? key_i.kc  : key_i.ka;
  assign kb     = upd_v1 ? key_i.kd  : key_i.kb;
  assign mix    = tea_mix(src, data_i.sum, ka, kb);
  assign res    = data_i.dec ? (tgt - mix) : (tgt + mix);

  // Next contents; the sum steps after the second half of each round.
  always_comb begin
    data_d     = data_i;
    if (upd_v1) begin
      data_d.v1 = res;
    end else begin
      data_d.v0 = res;
    end
    if (phase_i) begin
      data_d.sum = data_i.dec ? (data_i.sum - TEA_DELTA) : (data_i.sum + TEA_DELTA);
    end
  end

  // Occupancy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[design/tea_out_buf.sv]
// Two-entry output buffer between the cell chain and the response channel.
module tea_out_buf import tea_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [63:0] word_i,
  output logic        room_o,
  tea_rsp_if.source   rsp
);

  logic [63:0] mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        pop;

  assign pop       = rsp.valid && rsp.ready;
  assign rsp.valid = (cnt_q != 2'd0);
  assign rsp.block_out = mem_q[rd_ptr_q];
  // Room for a new word if not full, or if the head word leaves this cycle.
  assign room_o    = (cnt_q != 2'd2) || rsp.ready;

  // Pointer and count update.
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop    ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

endmodule

[design/tea_block_cipher.sv]
// Top level of the TEA block cipher: a chain of half-round cells and an output buffer.
//
//   Channel | Dir | Payload                        | Handshake
//   req     | in  | req_type (1), block_in (64)    | valid / ready
//   rsp     | out | block_out (64)                 | valid / ready
//   cfg     | in  | index (3), data (32)           | valid / ready (always ready)
//
// One word is accepted every cycle while the chain is not halted; each passes 2 * ROUND_COUNT
// half-round cells, each a register, and then the output buffer, from which its result
// is offered on the response channel.
// Reset clears the key, the byte order and all occupancy flags; no clearing pass.
// The chain moves as a whole and halts only while the two-entry output buffer is
// full and the response side does not take a word.
module tea_block_cipher import tea_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tea_req_if.sink   req,
  tea_rsp_if.source rsp,
  tea_cfg_if.sink   cfg
);

  key_t        key;
  logic        byte_order;
  logic        en;
  logic        valid_chain [NUM_CELLS+1];
  stage_t      data_chain  [NUM_CELLS+1];
  logic [63:0] packed_word;

  tea_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg          (cfg),
    .key_o        (key),
    .byte_order_o (byte_order)
  );

  // Entry of the chain: unpack the halves and pick the starting sum.
  assign req.ready          = en;
  assign valid_chain[0]     = req.valid;
  assign data_chain[0].dec  = (req_type_e'(req.req_type) == REQ_DECRYPT);
  assign data_chain[0].v0   = order_half(req.block_in[31:0], byte_order);
  assign data_chain[0].v1   = order_half(req.block_in[63:32], byte_order);
  assign data_chain[0].sum  = data_chain[0].dec ? TEA_DEC_SUM : TEA_DELTA;

  // Row of half-round cells; odd cells finish a round.
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    tea_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .phase_i (1'(k % 2)),
      .key_i   (key),
      .valid_i (valid_chain[k]),
      .data_i  (data_chain[k]),
      .valid_o (valid_chain[k+1]),
      .data_o  (data_chain[k+1])
    );
  end

  // Repack the halves in the selected byte order.
  assign packed_word = {order_half(data_chain[NUM_CELLS].v1, byte_order),
                        order_half(data_chain[NUM_CELLS].v0, byte_order)};

  tea_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (en && valid_chain[NUM_CELLS]),
    .word_i (packed_word),
    .room_o (en),
    .rsp    (rsp)
  );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the TEA block cipher, with random stalls on both channels.
module tb_top;
  import tea_pkg::*;

  localparam logic [31:0] GOLDEN_RATIO = 32'h9E37_79B9;
  localparam int unsigned FLUSH_CYCLES = 2 * ROUND_COUNT + 16;
  localparam int unsigned RAND_PHASES  = 6;
  localparam int unsigned PHASE_BLOCKS = 250;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned CLK_HALF_NS  = 6;
  localparam int unsigned LIMIT_NS     = 1_500_000;

  // One request word: the operation and the eight bytes it works on.
  typedef struct packed {
    req_type_e   op;
    logic [63:0] blk;
  } tea_req_t;

  logic clk_i;
  logic rst_ni;

  tea_req_if req_if ();
  tea_rsp_if rsp_if ();
  tea_cfg_if cfg_if ();

  tea_block_cipher u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_if),
    .rsp    (rsp_if),
    .cfg    (cfg_if)
  );

  // Request words still to be driven, and ciphertext or plaintext words still to come back.
  tea_req_t    cipher_req_q[$];
  logic [63:0] tea_result_q[$];

  // The testbench's own copy of the key and the byte order.
  logic [31:0] key_a;
  logic [31:0] key_b;
  logic [31:0] key_c;
  logic [31:0] key_d;
  logic        big_endian;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned fault_cnt;

  // Reads one 32-bit half of the block in the configured byte order (also used to write back).
  function automatic logic [31:0] order_word(input logic [31:0] raw);
    logic [31:0] w;
    w = raw;
    if (big_endian) begin
      for (int i = 0; i < 4; i++) w[8*i +: 8] = raw[8*(3-i) +: 8];
    end
    return w;
  endfunction

  // Full TEA encryption or decryption of one block under the current key.
  function automatic logic [63:0] tea_crypt(input req_type_e op, input logic [63:0] blk);
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] sum;
    y = order_word(blk[31:0]);
    z = order_word(blk[63:32]);
    if (op == REQ_ENCRYPT) begin
      sum = '0;
      for (int r = 0; r < ROUND_COUNT; r++) begin
        sum = sum + GOLDEN_RATIO;
        y = y + ((((z << 4) + key_a) ^ (z + sum)) ^ ((z >> 5) + key_b));
        z = z + ((((y << 4) + key_c) ^ (y + sum)) ^ ((y >> 5) + key_d));
      end
    end else begin
      sum = GOLDEN_RATIO * 32'(ROUND_COUNT);
      for (int r = 0; r < ROUND_COUNT; r++) begin
        z = z - ((((y << 4) + key_c) ^ (y + sum)) ^ ((y >> 5) + key_d));
        y = y - ((((z << 4) + key_a) ^ (z + sum)) ^ ((z >> 5) + key_b));
        sum = sum - GOLDEN_RATIO;
      end
    end
    return {order_word(z), order_word(y)};
  endfunction

  function automatic void push_block(input req_type_e op, input logic [63:0] blk);
    tea_req_t w;
    w.op  = op;
    w.blk = blk;
    cipher_req_q.push_back(w);
  endfunction

  // Writes one register and mirrors it once the word has been taken.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_KEY_A:      key_a = value;
      CFG_KEY_B:      key_b = value;
      CFG_KEY_C:      key_c = value;
      CFG_KEY_D:      key_d = value;
      CFG_BYTE_ORDER: big_endian = value[0];
      default: ;
    endcase
  endtask

  // Loads a full key and byte order, plus one write to an index that holds no register.
  task automatic load_setting(input logic [31:0] ka, input logic [31:0] kb,
                              input logic [31:0] kc, input logic [31:0] kd,
                              input logic [31:0] order_data);
    logic [CFG_IDX_W-1:0] spare_idx;
    spare_idx = CFG_IDX_W'($urandom_range(int'(CFG_BYTE_ORDER) + 1, (1 << CFG_IDX_W) - 1));
    write_reg(CFG_KEY_A, ka);
    write_reg(CFG_KEY_B, kb);
    write_reg(spare_idx, $urandom);
    write_reg(CFG_KEY_C, kc);
    write_reg(CFG_KEY_D, kd);
    write_reg(CFG_BYTE_ORDER, order_data);
  endtask

  // Waits on the falling edge until every word has been sent and answered.
  task automatic wait_idle();
    @(negedge clk_i);
    while (cipher_req_q.size() != 0 || req_if.valid || tea_result_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  // Hard limit on the run time.
  initial begin
    #(LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

  // Request driver: takes the next word from the queue unless it chooses to idle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        tea_result_q.push_back(tea_crypt(req_type_e'(req_if.req_type), req_if.block_in));
      end
      if (!req_if.valid || req_if.ready) begin
        if (cipher_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          tea_req_t w;
          w = cipher_req_q.pop_front();
          req_if.valid    <= 1'b1;
          req_if.req_type <= w.op;
          req_if.block_in <= w.blk;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: stalls at random and checks every word taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (tea_result_q.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= MAX_REPORTS) begin
            $display("response word %h arrived with nothing outstanding", rsp_if.block_out);
          end
        end else begin
          logic [63:0] want;
          want = tea_result_q.pop_front();
          if (rsp_if.block_out !== want) begin
            fault_cnt++;
            if (fault_cnt <= MAX_REPORTS) begin
              $display("block_out mismatch: expected %h, got %h", want, rsp_if.block_out);
            end
          end
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Stimulus: reset, a directed part, then random phases under changing keys and stalls.
  initial begin
    logic [63:0] blk;
    logic [31:0] order_data;
    int unsigned pushed;
    int unsigned pick;

    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_ENCRYPT;
    req_if.block_in = '0;
    rsp_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_KEY_A;
    cfg_if.data     = '0;
    key_a           = '0;
    key_b           = '0;
    key_c           = '0;
    key_d           = '0;
    big_endian      = 1'b0;
    fault_cnt       = 0;
    send_idle_pct   = 26;
    recv_idle_pct   = 59;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting: all-zero key, little-endian halves.
    push_block(REQ_ENCRYPT, '0);
    push_block(REQ_DECRYPT, '0);
    push_block(REQ_ENCRYPT, '1);
    push_block(REQ_DECRYPT, '1);
    push_block(REQ_ENCRYPT, 64'h0123_4567_89AB_CDEF);
    push_block(REQ_DECRYPT, 64'h8000_0000_0000_0001);
    wait_idle();

    // All-ones key, big-endian with the unused upper bits of the order register set.
    load_setting('1, '1, '1, '1, 32'hFFFF_FFFF);
    push_block(REQ_ENCRYPT, '0);
    push_block(REQ_DECRYPT, '0);
    push_block(REQ_ENCRYPT, '1);
    push_block(REQ_DECRYPT, '1);
    push_block(REQ_ENCRYPT, 64'h5555_5555_5555_5555);
    push_block(REQ_DECRYPT, 64'hAAAA_AAAA_AAAA_AAAA);
    push_block(REQ_ENCRYPT, 64'h0000_0001_8000_0000);
    wait_idle();

    // Random key, little-endian with junk in the upper bits; a round trip too.
    load_setting($urandom, $urandom, $urandom, $urandom, 32'hFFFF_FFFE);
    blk = {$urandom, $urandom};
    push_block(REQ_ENCRYPT, blk);
    push_block(REQ_DECRYPT, tea_crypt(REQ_ENCRYPT, blk));
    push_block(REQ_ENCRYPT, 64'hFEDC_BA98_7654_3210);
    push_block(REQ_DECRYPT, 64'h0123_4567_89AB_CDEF);
    wait_idle();

    // Random phases: the stall pattern moves from the receiver to the sender, then away.
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p < 2) begin
        send_idle_pct = 26;
        recv_idle_pct = 59;
      end else if (p < 4) begin
        send_idle_pct = 59;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      order_data = $urandom;
      order_data[0] = p[0];
      if (p == 0) begin
        load_setting('1, '1, '1, '1, order_data);
      end else if (p == 1) begin
        load_setting('0, '0, '0, '0, order_data);
      end else begin
        load_setting($urandom, $urandom, $urandom, $urandom, order_data);
      end

      // Mostly random blocks, some extremes, and encrypt-then-decrypt pairs.
      pushed = 0;
      while (pushed < PHASE_BLOCKS) begin
        pick = $urandom_range(15);
        if (pick == 0) begin
          push_block(req_type_e'($urandom_range(1)), '0);
          pushed++;
        end else if (pick == 1) begin
          push_block(req_type_e'($urandom_range(1)), '1);
          pushed++;
        end else if (pick < 5) begin
          blk = {$urandom, $urandom};
          push_block(REQ_ENCRYPT, blk);
          push_block(REQ_DECRYPT, tea_crypt(REQ_ENCRYPT, blk));
          pushed += 2;
        end else begin
          push_block(req_type_e'($urandom_range(1)), {$urandom, $urandom});
          pushed++;
        end
      end
      wait_idle();
    end

    repeat (FLUSH_CYCLES) @(posedge clk_i);
    if (fault_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
